// ===== sv/sgm_pkg.sv =====
package sgm_pkg;

  // sample width and the widths that follow from it
  localparam int SAMPLE_BITS = 8;
  // signed gradient: +-4*(2^S-1) needs S+2 magnitude bits and a sign
  localparam int G_BITS      = SAMPLE_BITS + 3;
  // one squared gradient, always below 2^(2S+4)
  localparam int SQH_BITS    = 2 * G_BITS - 2;
  // sum of both squares
  localparam int SQ_BITS     = SQH_BITS + 1;
  // sum of squares divided by sixteen
  localparam int V_BITS      = SQ_BITS - 4;
  localparam int ROOT_BITS   = (V_BITS + 1) / 2;
  localparam int VP_BITS     = 2 * ROOT_BITS;
  localparam int REM_BITS    = ROOT_BITS + 1;
  localparam int CMP_BITS    = REM_BITS + 4;
  localparam int MAG_BITS    = ROOT_BITS + 1;

  localparam logic [MAG_BITS-1:0] MAG_MAX = MAG_BITS'((1 << SAMPLE_BITS) - 1);

endpackage

// ===== sv/sgm_isqrt.sv =====
module sgm_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [sgm_pkg::VP_BITS-1:0]   in_v,
  input  logic [3:0]                    in_low,
  output logic                          out_valid,
  output logic [sgm_pkg::ROOT_BITS-1:0] out_root,
  output logic [sgm_pkg::REM_BITS-1:0]  out_rem,
  output logic [3:0]                    out_low
);
  import sgm_pkg::*;

  // one result bit per stage, radicand consumed two bits at a time from the top
  logic                  vld  [ROOT_BITS+1];
  logic [VP_BITS-1:0]    vp   [ROOT_BITS+1];
  logic [ROOT_BITS-1:0]  root [ROOT_BITS+1];
  logic [REM_BITS-1:0]   rem  [ROOT_BITS+1];
  logic [3:0]            low  [ROOT_BITS+1];

  assign vld[0]  = in_valid;
  assign vp[0]   = in_v;
  assign root[0] = '0;
  assign rem[0]  = '0;
  assign low[0]  = in_low;

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_step
    logic [REM_BITS+1:0]  rem_sh;
    logic [REM_BITS+1:0]  trial;
    logic [REM_BITS+1:0]  diff;
    logic                 take;
    logic [ROOT_BITS-1:0] root_next;
    logic [REM_BITS-1:0]  rem_next;

    always_comb begin
      rem_sh = {rem[k], vp[k][VP_BITS-1 -: 2]};
      trial  = (REM_BITS+2)'({root[k], 2'b01});
      diff   = rem_sh - trial;
      take   = (rem_sh >= trial);
      root_next = {root[k][ROOT_BITS-2:0], take};
      rem_next  = take ? diff[REM_BITS-1:0] : rem_sh[REM_BITS-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        vp[k+1]   <= {vp[k][VP_BITS-3:0], 2'b00};
        root[k+1] <= root_next;
        rem[k+1]  <= rem_next;
        low[k+1]  <= low[k];
      end
    end
  end

  assign out_valid = vld[ROOT_BITS];
  assign out_root  = root[ROOT_BITS];
  assign out_rem   = rem[ROOT_BITS];
  assign out_low   = low[ROOT_BITS];

endmodule

// ===== sv/sobel_gradient_magnitude.sv =====
// Sobel gradient magnitude of one 3x3 window of one sample channel. Each transfer
// carries the eight neighbours of the centre sample; the block returns
// round(sqrt(gx^2 + gy^2) / 4) with ties to even, saturated to the largest sample
// value with clipped set when saturation happens. It is a fully pipelined datapath
// of 3 + (SAMPLE_BITS + 1) + 1 register stages, and it takes one window in every
// cycle while the output is not stalled. The stages are the two Sobel sums, the
// two squares, their sum, one stage per bit of the integer square root, and the
// round/saturate stage that is also the output register. A stalled output freezes
// the whole pipeline; while the output is empty or being taken, the input is never
// stalled. There is no state beyond the pipeline.
module sobel_gradient_magnitude (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [sgm_pkg::SAMPLE_BITS-1:0] p_nw,
  input  logic [sgm_pkg::SAMPLE_BITS-1:0] p_n,
  input  logic [sgm_pkg::SAMPLE_BITS-1:0] p_ne,
  input  logic [sgm_pkg::SAMPLE_BITS-1:0] p_w,
  input  logic [sgm_pkg::SAMPLE_BITS-1:0] p_e,
  input  logic [sgm_pkg::SAMPLE_BITS-1:0] p_sw,
  input  logic [sgm_pkg::SAMPLE_BITS-1:0] p_s,
  input  logic [sgm_pkg::SAMPLE_BITS-1:0] p_se,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sgm_pkg::SAMPLE_BITS-1:0] magnitude,
  output logic                            clipped
);
  import sgm_pkg::*;

  // whole pipeline advances unless a finished result is held at the output
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: sobel sums, weights 1,2,1
  logic [SAMPLE_BITS+1:0] left_sum, right_sum, top_sum, bot_sum;
  logic [G_BITS-1:0]      gx_next, gy_next;
  logic                   s1_valid;
  logic [G_BITS-1:0]      gx, gy;

  always_comb begin
    left_sum  = (SAMPLE_BITS+2)'(p_nw) + (SAMPLE_BITS+2)'({p_w, 1'b0}) + (SAMPLE_BITS+2)'(p_sw);
    right_sum = (SAMPLE_BITS+2)'(p_ne) + (SAMPLE_BITS+2)'({p_e, 1'b0}) + (SAMPLE_BITS+2)'(p_se);
    top_sum   = (SAMPLE_BITS+2)'(p_nw) + (SAMPLE_BITS+2)'({p_n, 1'b0}) + (SAMPLE_BITS+2)'(p_ne);
    bot_sum   = (SAMPLE_BITS+2)'(p_sw) + (SAMPLE_BITS+2)'({p_s, 1'b0}) + (SAMPLE_BITS+2)'(p_se);
    // left minus right, top minus bottom, in two's complement
    gx_next   = G_BITS'(left_sum) - G_BITS'(right_sum);
    gy_next   = G_BITS'(top_sum) - G_BITS'(bot_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gx <= gx_next;
      gy <= gy_next;
    end
  end

  // stage 2: squares, nonnegative and below 2^SQH_BITS
  logic signed [2*G_BITS-1:0] prod_x, prod_y;
  logic                       s2_valid;
  logic [SQH_BITS-1:0]        sqx, sqy;

  assign prod_x = $signed(gx) * $signed(gx);
  assign prod_y = $signed(gy) * $signed(gy);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx <= prod_x[SQH_BITS-1:0];
      sqy <= prod_y[SQH_BITS-1:0];
    end
  end

  // stage 3: sum of squares
  logic               s3_valid;
  logic [SQ_BITS-1:0] sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq <= SQ_BITS'(sqx) + SQ_BITS'(sqy);
    end
  end

  // square root of sq/16 gives floor(sqrt(sq)/4); the dropped nibble rides along
  logic                 rt_valid;
  logic [ROOT_BITS-1:0] rt_root;
  logic [REM_BITS-1:0]  rt_rem;
  logic [3:0]           rt_low;

  sgm_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s3_valid),
    .in_v      (VP_BITS'(sq[SQ_BITS-1:4])),
    .in_low    (sq[3:0]),
    .out_valid (rt_valid),
    .out_root  (rt_root),
    .out_rem   (rt_rem),
    .out_low   (rt_low)
  );

  // final stage: round half to even, then saturate
  // sq - 16q^2 = 16*rem + low, compared against the halfway point 16q + 4
  logic [CMP_BITS-1:0] above, half;
  logic                round_up;
  logic [MAG_BITS-1:0] mag;
  logic                clip_next;

  always_comb begin
    above     = {rt_rem, rt_low};
    half      = CMP_BITS'({rt_root, 4'b0100});
    round_up  = (above > half) || ((above == half) && rt_root[0]);
    mag       = MAG_BITS'(rt_root) + MAG_BITS'(round_up);
    clip_next = (mag > MAG_MAX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= rt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      magnitude <= clip_next ? MAG_MAX[SAMPLE_BITS-1:0] : mag[SAMPLE_BITS-1:0];
      clipped   <= clip_next;
    end
  end

endmodule

// ===== tb/sobel_gradient_magnitude_test.sv =====
module sobel_gradient_magnitude_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sgm_pkg::SAMPLE_BITS;

  // run shape
  localparam int RESET_CYCLES  = 7;
  localparam int RANDOM_ITEMS  = 1425;
  localparam int TAIL_ITEMS    = 150;     // last windows go through with no idling
  localparam int DRAIN_POINT   = 400;     // sender holds off here until the pipe is empty
  localparam int SETTLE_CYCLES = 20;      // longer than the pipeline is deep
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;

  // hold-off sequencing of the sender
  localparam logic [1:0] DRAIN_ARMED = 2'd0;
  localparam logic [1:0] DRAIN_HOLD  = 2'd1;
  localparam logic [1:0] DRAIN_DONE  = 2'd2;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  // one 3x3 neighbourhood, centre left out
  typedef struct packed {
    sample_t nw;
    sample_t n;
    sample_t ne;
    sample_t w;
    sample_t e;
    sample_t sw;
    sample_t s;
    sample_t se;
  } window_t;

  typedef struct packed {
    sample_t magnitude;
    logic    clipped;
  } edge_result_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;

  // block inputs, all known from time zero
  logic    in_valid  = 1'b0;
  logic    out_stall = 1'b0;
  sample_t p_nw = '0;
  sample_t p_n  = '0;
  sample_t p_ne = '0;
  sample_t p_w  = '0;
  sample_t p_e  = '0;
  sample_t p_sw = '0;
  sample_t p_s  = '0;
  sample_t p_se = '0;

  logic    in_stall;
  logic    out_valid;
  sample_t magnitude;
  logic    clipped;

  sobel_gradient_magnitude dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .p_nw      (p_nw),
    .p_n       (p_n),
    .p_ne      (p_ne),
    .p_w       (p_w),
    .p_e       (p_e),
    .p_sw      (p_sw),
    .p_s       (p_s),
    .p_se      (p_se),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .magnitude (magnitude),
    .clipped   (clipped)
  );

  // windows waiting to go out, and edge strengths waiting to come back
  window_t      pending_windows[$];
  edge_result_t expected_strengths[$];

  int           cycle_count     = 0;
  int           error_count     = 0;
  int           windows_sent    = 0;
  int           windows_taken   = 0;   // input transfers seen
  int           strengths_seen  = 0;   // output transfers matched to a prediction
  int           sender_gap      = 0;
  int           stall_left      = 0;
  int           quiet_left      = 0;
  logic         quiet           = 1'b0;
  logic         tail_phase      = 1'b0;
  logic [1:0]   drain_state     = DRAIN_ARMED;

  initial begin
    forever #2 clk = ~clk;
  end

  // generous watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL sobel_gradient_magnitude");
      $finish;
    end
  end

  function automatic window_t make_window(int nw, int n, int ne, int w, int e, int sw, int s,
                                          int se);
    window_t win;
    win.nw = sample_t'(nw);
    win.n  = sample_t'(n);
    win.ne = sample_t'(ne);
    win.w  = sample_t'(w);
    win.e  = sample_t'(e);
    win.sw = sample_t'(sw);
    win.s  = sample_t'(s);
    win.se = sample_t'(se);
    return win;
  endfunction

  // sobel sums, exact integer root, round half to even on sqrt(sum_sq)/4, saturate
  function automatic edge_result_t predict_edge_strength(window_t win);
    int              gx;
    int              gy;
    longint unsigned sum_sq;
    longint unsigned root;
    longint unsigned trial;
    longint unsigned quarter;
    longint unsigned half_sq;
    longint unsigned mag;
    edge_result_t    res;
    // gx: left column minus right column, gy: top row minus bottom row
    gx = (int'(win.nw) + 2 * int'(win.w) + int'(win.sw))
       - (int'(win.ne) + 2 * int'(win.e) + int'(win.se));
    gy = (int'(win.nw) + 2 * int'(win.n) + int'(win.ne))
       - (int'(win.sw) + 2 * int'(win.s) + int'(win.se));
    sum_sq = longint'(gx * gx) + longint'(gy * gy);
    // floor square root, one bit at a time from the top
    root = 0;
    for (int b = SAMPLE_BITS + 3; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= sum_sq) root = trial;
    end
    quarter = root >> 2;
    // root/4 sits exactly at quarter + 0.5 when sum_sq is (4q+2)^2
    half_sq = (4 * quarter + 2) * (4 * quarter + 2);
    mag = quarter;
    if (sum_sq > half_sq || (sum_sq == half_sq && quarter[0])) mag = quarter + 1;
    res.clipped   = (mag > SAMPLE_MAX);
    res.magnitude = res.clipped ? sample_t'(SAMPLE_MAX) : sample_t'(mag);
    return res;
  endfunction

  task automatic report_mismatch(string field_name, int got, int want);
    $display("mismatch at cycle %0d, result %0d: %s got %0d, expected %0d",
             cycle_count, strengths_seen, field_name, got, want);
    error_count++;
  endtask

  // sender: presents the next window once the bus is free, with random gaps,
  // one hold-off until the pipeline has drained, and a calm tail
  always @(posedge clk) begin
    window_t item;
    if (rst) begin
      in_valid    <= 1'b0;
      sender_gap  <= 0;
      drain_state <= DRAIN_ARMED;
    end else if (!in_valid || !in_stall) begin
      // whatever was on the bus transfers at this edge, so the bus is ours
      if (sender_gap != 0) begin
        in_valid   <= 1'b0;
        sender_gap <= sender_gap - 1;
      end else if (drain_state == DRAIN_HOLD) begin
        // the counters update nonblocking, but the last transfer is already counted here
        in_valid <= 1'b0;
        if (windows_taken == strengths_seen) drain_state <= DRAIN_DONE;
      end else if (drain_state == DRAIN_ARMED && windows_sent == DRAIN_POINT) begin
        in_valid    <= 1'b0;
        drain_state <= DRAIN_HOLD;
      end else if (pending_windows.size() != 0) begin
        item = pending_windows.pop_front();
        p_nw <= item.nw;
        p_n  <= item.n;
        p_ne <= item.ne;
        p_w  <= item.w;
        p_e  <= item.e;
        p_sw <= item.sw;
        p_s  <= item.s;
        p_se <= item.se;
        in_valid     <= 1'b1;
        windows_sent <= windows_sent + 1;
        tail_phase   <= (pending_windows.size() < TAIL_ITEMS);
        // gap opens after this window has transferred
        if (!quiet && pending_windows.size() >= TAIL_ITEMS && $urandom_range(0, 4) == 0)
          sender_gap <= $urandom_range(1, 10);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall bursts, switched off in quiet stretches and in the tail
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      quiet_left <= 0;
      quiet      <= 1'b0;
    end else begin
      if (quiet_left == 0) begin
        quiet      <= ($urandom_range(0, 3) == 0);
        quiet_left <= 63;
      end else begin
        quiet_left <= quiet_left - 1;
      end
      if (stall_left != 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (!quiet && !tail_phase && $urandom_range(0, 5) == 0) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 9);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor: checks each output transfer against the oldest prediction, then
  // predicts for the input transfer of the same edge
  always @(posedge clk) begin
    edge_result_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_strengths.size() == 0) begin
          report_mismatch("unexpected result, magnitude", magnitude, -1);
        end else begin
          want = expected_strengths.pop_front();
          if (magnitude !== want.magnitude)
            report_mismatch("magnitude", magnitude, want.magnitude);
          if (clipped !== want.clipped)
            report_mismatch("clipped", clipped, want.clipped);
          strengths_seen <= strengths_seen + 1;
        end
      end
      if (in_valid && !in_stall) begin
        expected_strengths.push_back(predict_edge_strength(
          make_window(p_nw, p_n, p_ne, p_w, p_e, p_sw, p_s, p_se)));
        windows_taken <= windows_taken + 1;
      end
    end
  end

  initial begin
    window_t item;
    int      kind;
    int      lvl_a;
    int      lvl_b;
    int      v;

    // directed windows
    pending_windows.push_back(make_window(0, 0, 0, 0, 0, 0, 0, 0));
    pending_windows.push_back(make_window(255, 255, 255, 255, 255, 255, 255, 255));
    // each neighbour alone at full scale, covering every weight and sign
    for (int k = 0; k < 8; k++) begin
      item = '0;
      item[k*SAMPLE_BITS +: SAMPLE_BITS] = sample_t'(SAMPLE_MAX);
      pending_windows.push_back(item);
    end
    // full vertical and horizontal edges in both directions: 1020/4, no clip
    pending_windows.push_back(make_window(255, 0, 0, 255, 0, 255, 0, 0));
    pending_windows.push_back(make_window(0, 0, 255, 0, 255, 0, 0, 255));
    pending_windows.push_back(make_window(255, 255, 255, 0, 0, 0, 0, 0));
    pending_windows.push_back(make_window(0, 0, 0, 0, 0, 255, 255, 255));
    // diagonal corners: both gradients large, saturates
    pending_windows.push_back(make_window(255, 255, 0, 255, 0, 0, 0, 0));
    pending_windows.push_back(make_window(0, 0, 0, 0, 255, 0, 255, 255));
    // right at the saturation boundary: 255.47 stays, 256 clips
    pending_windows.push_back(make_window(255, 31, 0, 255, 0, 255, 0, 0));
    pending_windows.push_back(make_window(255, 32, 0, 255, 0, 255, 0, 0));
    // exact halves 0.5, 1.5, 2.5, 3.5 go to the even neighbour
    pending_windows.push_back(make_window(0, 0, 0, 1, 0, 0, 0, 0));
    pending_windows.push_back(make_window(0, 0, 0, 3, 0, 0, 0, 0));
    pending_windows.push_back(make_window(0, 0, 0, 5, 0, 0, 0, 0));
    pending_windows.push_back(make_window(0, 0, 0, 7, 0, 0, 0, 0));
    // exact half with both gradients nonzero: gx 6, gy 8
    pending_windows.push_back(make_window(0, 4, 0, 3, 0, 0, 0, 0));
    // alternating bit patterns
    pending_windows.push_back(make_window(8'haa, 8'h55, 8'haa, 8'h55, 8'haa, 8'h55, 8'haa,
                                          8'h55));
    pending_windows.push_back(make_window(8'h55, 8'haa, 8'h55, 8'haa, 8'h55, 8'haa, 8'h55,
                                          8'haa));

    // random windows, shaped toward edges, small gradients and the rails
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      kind  = $urandom_range(0, 9);
      lvl_a = $urandom_range(0, SAMPLE_MAX);
      lvl_b = $urandom_range(0, SAMPLE_MAX);
      if (kind == 4 || kind == 5) begin
        // step edge between two levels, middle samples free
        case ($urandom_range(0, 2))
          0: item = make_window(lvl_a, $urandom_range(0, SAMPLE_MAX), lvl_b, lvl_a, lvl_b,
                                lvl_a, $urandom_range(0, SAMPLE_MAX), lvl_b);
          1: item = make_window(lvl_a, lvl_a, lvl_a, $urandom_range(0, SAMPLE_MAX),
                                $urandom_range(0, SAMPLE_MAX), lvl_b, lvl_b, lvl_b);
          default: item = make_window(lvl_a, lvl_a, $urandom_range(0, SAMPLE_MAX), lvl_a,
                                      lvl_b, $urandom_range(0, SAMPLE_MAX), lvl_b, lvl_b);
        endcase
      end else begin
        for (int k = 0; k < 8; k++) begin
          case (kind)
            6: begin
              // nearly flat patch
              v = lvl_a + $urandom_range(0, 3);
              if (v > SAMPLE_MAX) v = SAMPLE_MAX;
            end
            7: v = $urandom_range(0, 7);   // tiny gradients, many exact halves
            8: v = ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : 0;
            9: v = ($urandom_range(0, 1) != 0) ? SAMPLE_MAX - $urandom_range(0, 5)
                                                : $urandom_range(0, 5);
            default: v = $urandom_range(0, SAMPLE_MAX);
          endcase
          item[k*SAMPLE_BITS +: SAMPLE_BITS] = sample_t'(v);
        end
      end
      pending_windows.push_back(item);
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // sampled away from the active edge so the queue and counters are settled
    @(negedge clk);
    while (!(pending_windows.size() == 0 && !in_valid && windows_taken == strengths_seen))
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (expected_strengths.size() != 0) begin
      $display("%0d results never arrived", expected_strengths.size());
      error_count += expected_strengths.size();
    end
    if (error_count == 0) begin
      $display("PASS sobel_gradient_magnitude");
    end else begin
      $display("FAIL sobel_gradient_magnitude");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/sgm_pkg.sv
sv/sgm_isqrt.sv
sv/sobel_gradient_magnitude.sv
tb/sobel_gradient_magnitude_test.sv
